/* hw/rtl/kcl_pkg.sv */
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants of the keypad code lock
// Key codes, event codes, mode bits, register indexes and the config and
// result bundles used between the lock modules.
// ----------------------------------------------------------------------------
`default_nettype none

package kcl_pkg;

  localparam int KEY_W  = 4;
  localparam int CFG_W  = 24;
  localparam int LIM_W  = 4;
  localparam int IDX_W  = 2;
  localparam int DCNT_W = 3;
  localparam int MODE_W = 3;

  localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [KEY_W-1:0] KEY_A         = 4'd10;
  localparam logic [KEY_W-1:0] KEY_B         = 4'd11;
  localparam logic [KEY_W-1:0] KEY_C         = 4'd12;
  localparam logic [KEY_W-1:0] KEY_D         = 4'd13;
  localparam logic [KEY_W-1:0] KEY_CANCEL    = 4'd14;

  localparam logic [MODE_W-1:0] MODE_ADD = 3'b001;
  localparam logic [MODE_W-1:0] MODE_DEL = 3'b010;
  localparam logic [MODE_W-1:0] MODE_FP  = 3'b100;

  localparam logic [LIM_W-1:0] ERR_MAX = 4'hF;

  localparam logic [IDX_W-1:0] REG_FACTORY = 2'd0;
  localparam logic [IDX_W-1:0] REG_RESTORE = 2'd1;
  localparam logic [IDX_W-1:0] REG_CLEAR   = 2'd2;
  localparam logic [IDX_W-1:0] REG_LIMIT   = 2'd3;

  localparam logic [CFG_W-1:0] RESTORE_RST = 24'h201306;
  localparam logic [CFG_W-1:0] CLEAR_RST   = 24'h200136;
  localparam logic [LIM_W-1:0] LIMIT_RST   = 4'd3;

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_DIGIT     = 4'd1,
    EV_UNLOCK    = 4'd2,
    EV_WRONG     = 4'd3,
    EV_LOCKOUT   = 4'd4,
    EV_CHANGE_ON = 4'd5,
    EV_AGAIN     = 4'd6,
    EV_SAVED     = 4'd7,
    EV_MISMATCH  = 4'd8,
    EV_REFUSED   = 4'd9,
    EV_RESTORED  = 4'd10,
    EV_CLEARFP   = 4'd11,
    EV_CANCEL    = 4'd12,
    EV_MODE      = 4'd13
  } kcl_event_t;

  typedef struct packed {
    logic [CFG_W-1:0] factory_code;
    logic [CFG_W-1:0] restore_trigger;
    logic [CFG_W-1:0] clear_trigger;
    logic [LIM_W-1:0] error_limit;
  } kcl_cfg_t;

  typedef struct packed {
    kcl_event_t        event_res;
    logic              relay_on;
    logic [DCNT_W-1:0] digits_entered;
    logic              card_add_mode;
    logic              card_delete_mode;
    logic              finger_enroll_mode;
    logic              locked_out;
  } kcl_res_t;

endpackage

`default_nettype wire

/* hw/rtl/kcl_key_if.sv */
// ----------------------------------------------------------------------------
// kcl_key_if: key input channel
// Valid/ready channel carrying one key code per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface kcl_key_if;
  logic                     valid;
  logic                     ready;
  logic [kcl_pkg::KEY_W-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

`default_nettype wire

/* hw/rtl/kcl_res_if.sv */
// ----------------------------------------------------------------------------
// kcl_res_if: result channel
// Valid/ready channel carrying one lock result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface kcl_res_if;
  logic                      valid;
  logic                      ready;
  logic [3:0]                event_res;
  logic                      relay_on;
  logic [kcl_pkg::DCNT_W-1:0] digits_entered;
  logic                      card_add_mode;
  logic                      card_delete_mode;
  logic                      finger_enroll_mode;
  logic                      locked_out;

  modport source (output valid, output event_res, output relay_on, output digits_entered,
                  output card_add_mode, output card_delete_mode,
                  output finger_enroll_mode, output locked_out, input ready);
  modport sink   (input valid, input event_res, input relay_on, input digits_entered,
                  input card_add_mode, input card_delete_mode,
                  input finger_enroll_mode, input locked_out, output ready);
endinterface

`default_nettype wire

/* hw/rtl/kcl_cfg_regs.sv */
// ----------------------------------------------------------------------------
// kcl_cfg_regs: configuration registers
// Factory code, restore and clear triggers and error limit, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module kcl_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [kcl_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [kcl_pkg::CFG_W-1:0]  cfg_data,
  output kcl_pkg::kcl_cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.factory_code    <= '0;
      cfg.restore_trigger <= kcl_pkg::RESTORE_RST;
      cfg.clear_trigger   <= kcl_pkg::CLEAR_RST;
      cfg.error_limit     <= kcl_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kcl_pkg::REG_FACTORY: cfg.factory_code    <= cfg_data;
        kcl_pkg::REG_RESTORE: cfg.restore_trigger <= cfg_data;
        kcl_pkg::REG_CLEAR:   cfg.clear_trigger   <= cfg_data;
        kcl_pkg::REG_LIMIT:   cfg.error_limit     <= cfg_data[kcl_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/kcl_core.sv */
// ----------------------------------------------------------------------------
// kcl_core: lock state and key decode
// Holds the entry, codes, counters and flags; applies one key per step and
// presents the result of that key.
// ----------------------------------------------------------------------------
`default_nettype none

module kcl_core #(
  parameter int CODE_DIGITS = 6
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire kcl_pkg::kcl_cfg_t         cfg,
  input  wire logic                      step,
  input  wire logic [kcl_pkg::KEY_W-1:0] key,
  output kcl_pkg::kcl_res_t              res
);

  localparam int CODE_W = CODE_DIGITS * 4;
  localparam int CMP_W  = (CODE_W > kcl_pkg::CFG_W) ? CODE_W : kcl_pkg::CFG_W;
  localparam int CNT_W  = $clog2(CODE_DIGITS + 1);

  logic [CODE_W-1:0]         entry_code, entry_code_next;
  logic [CNT_W-1:0]          entry_count, entry_count_next;
  logic [CMP_W-1:0]          stored_code, stored_code_next;
  logic [CODE_W-1:0]         staged_code, staged_code_next;
  logic [1:0]                correct_count, correct_count_next;
  logic [kcl_pkg::LIM_W-1:0] error_count, error_count_next;
  logic                      change_enabled, change_enabled_next;
  logic [1:0]                change_entries, change_entries_next;
  logic                      passed_flag, passed_flag_next;
  logic                      relay_state, relay_state_next;
  logic                      lock_state, lock_state_next;
  logic [kcl_pkg::MODE_W-1:0] mode_flags, mode_flags_next;

  kcl_pkg::kcl_event_t        ev;
  logic                       go_idle, clr_entry, entry_full;
  logic [kcl_pkg::MODE_W-1:0] mode_bit, mode_now;
  logic [1:0]                 cc_inc, ce_inc;
  logic [kcl_pkg::LIM_W-1:0]  err_inc;
  logic [CMP_W-1:0]           entry_ext;

  assign entry_full = (entry_count == CNT_W'(CODE_DIGITS));
  assign entry_ext  = CMP_W'(entry_code);
  assign cc_inc     = correct_count + 2'd1;
  assign ce_inc     = change_entries + 2'd1;
  assign err_inc    = (error_count != kcl_pkg::ERR_MAX) ? error_count + 4'd1 : error_count;
  assign mode_bit   = (key == kcl_pkg::KEY_A) ? kcl_pkg::MODE_ADD : kcl_pkg::MODE_DEL;

  always_comb begin
    entry_code_next     = entry_code;
    entry_count_next    = entry_count;
    stored_code_next    = stored_code;
    staged_code_next    = staged_code;
    correct_count_next  = correct_count;
    error_count_next    = error_count;
    change_enabled_next = change_enabled;
    change_entries_next = change_entries;
    passed_flag_next    = passed_flag;
    relay_state_next    = relay_state;
    lock_state_next     = lock_state;
    mode_flags_next     = mode_flags;
    ev                  = kcl_pkg::EV_NONE;
    go_idle             = 1'b0;
    clr_entry           = 1'b0;
    mode_now            = '0;

    if (!lock_state) begin
      priority if (key <= kcl_pkg::KEY_DIGIT_MAX) begin
        if (mode_flags == '0 && !entry_full) begin
          entry_code_next  = {entry_code[CODE_W-5:0], key};
          entry_count_next = entry_count + CNT_W'(1);
          ev               = kcl_pkg::EV_DIGIT;
        end
      end else if (key == kcl_pkg::KEY_A || key == kcl_pkg::KEY_B) begin
        if ((mode_flags & kcl_pkg::MODE_FP) == '0) begin
          mode_now        = (mode_flags & mode_bit) ^ mode_bit;
          mode_flags_next = mode_now;
          ev              = kcl_pkg::EV_MODE;
          go_idle         = (mode_now == '0);
        end
      end else if (key == kcl_pkg::KEY_C) begin
        if ((mode_flags & (kcl_pkg::MODE_ADD | kcl_pkg::MODE_DEL)) == '0) begin
          mode_now        = mode_flags ^ kcl_pkg::MODE_FP;
          mode_flags_next = mode_now;
          ev              = kcl_pkg::EV_MODE;
          go_idle         = ((mode_now & kcl_pkg::MODE_FP) == '0);
        end
      end else if (mode_flags == '0) begin
        unique case (key)
          kcl_pkg::KEY_D: begin
            if (!passed_flag) begin
              clr_entry = 1'b1;
              ev        = kcl_pkg::EV_REFUSED;
            end else if (change_enabled && entry_full) begin
              clr_entry = 1'b1;
              if (ce_inc == 2'd2) begin
                if (staged_code == entry_code) begin
                  stored_code_next = CMP_W'(staged_code);
                  ev               = kcl_pkg::EV_SAVED;
                end else begin
                  ev = kcl_pkg::EV_MISMATCH;
                end
                change_enabled_next = 1'b0;
                change_entries_next = 2'd0;
                correct_count_next  = 2'd0;
              end else begin
                staged_code_next    = entry_code;
                change_entries_next = ce_inc;
                ev                  = kcl_pkg::EV_AGAIN;
              end
            end
          end
          kcl_pkg::KEY_CANCEL: begin
            passed_flag_next    = 1'b0;
            change_enabled_next = 1'b0;
            change_entries_next = 2'd0;
            error_count_next    = '0;
            go_idle             = 1'b1;
            ev                  = kcl_pkg::EV_CANCEL;
          end
          default: begin
            if (entry_full) begin
              clr_entry = 1'b1;
              if (entry_ext == CMP_W'(cfg.restore_trigger)) begin
                stored_code_next = CMP_W'(cfg.factory_code);
                ev               = kcl_pkg::EV_RESTORED;
              end else if (entry_ext == CMP_W'(cfg.clear_trigger)) begin
                go_idle = 1'b1;
                ev      = kcl_pkg::EV_CLEARFP;
              end else if (entry_ext == stored_code) begin
                if (cc_inc == 2'd1) begin
                  correct_count_next = cc_inc;
                  relay_state_next   = 1'b1;
                  passed_flag_next   = 1'b1;
                  ev                 = kcl_pkg::EV_UNLOCK;
                end else begin
                  change_enabled_next = 1'b1;
                  correct_count_next  = 2'd0;
                  ev                  = kcl_pkg::EV_CHANGE_ON;
                end
              end else begin
                error_count_next = err_inc;
                if (err_inc >= cfg.error_limit) begin
                  lock_state_next  = 1'b1;
                  relay_state_next = 1'b0;
                  ev               = kcl_pkg::EV_LOCKOUT;
                end else begin
                  ev = kcl_pkg::EV_WRONG;
                end
              end
            end
          end
        endcase
      end else begin
        // D, cancel and enter are ignored while a mode is active
      end
    end

    if (go_idle) begin
      clr_entry          = 1'b1;
      correct_count_next = 2'd0;
      relay_state_next   = 1'b0;
    end
    if (clr_entry) begin
      entry_code_next  = '0;
      entry_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_code     <= '0;
      entry_count    <= '0;
      stored_code    <= '0;
      correct_count  <= '0;
      error_count    <= '0;
      change_enabled <= 1'b0;
      change_entries <= '0;
      passed_flag    <= 1'b0;
      relay_state    <= 1'b0;
      lock_state     <= 1'b0;
      mode_flags     <= '0;
    end else if (step) begin
      entry_code     <= entry_code_next;
      entry_count    <= entry_count_next;
      stored_code    <= stored_code_next;
      correct_count  <= correct_count_next;
      error_count    <= error_count_next;
      change_enabled <= change_enabled_next;
      change_entries <= change_entries_next;
      passed_flag    <= passed_flag_next;
      relay_state    <= relay_state_next;
      lock_state     <= lock_state_next;
      mode_flags     <= mode_flags_next;
    end
  end

  // staged code is only compared after it was written
  always_ff @(posedge clk) begin
    if (step) begin
      staged_code <= staged_code_next;
    end
  end

  always_comb begin
    res.event_res          = ev;
    res.relay_on           = relay_state_next;
    res.digits_entered     = kcl_pkg::DCNT_W'(entry_count_next);
    res.card_add_mode      = mode_flags_next[0];
    res.card_delete_mode   = mode_flags_next[1];
    res.finger_enroll_mode = mode_flags_next[2];
    res.locked_out         = lock_state_next;
  end

endmodule

`default_nettype wire

/* hw/rtl/keypad_code_lock.sv */
// ----------------------------------------------------------------------------
// keypad_code_lock: keypad code lock, top level
// The key is held in the key register and its result in the result register.
// Throughput: one key per cycle while the result channel is not stalled.
// While a result waits, one more key is held in the key register, then keys stall.
// Reset (rst, synchronous): clears entry, counters, flags and the stored code,
// and loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_code_lock #(
  parameter int CODE_DIGITS = 6
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [kcl_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [kcl_pkg::CFG_W-1:0] cfg_data,
  kcl_key_if.sink                        keypad,
  kcl_res_if.source                      result
);

  kcl_pkg::kcl_cfg_t         cfg;
  kcl_pkg::kcl_res_t         core_res, res_q;
  logic                      in_valid;
  logic [kcl_pkg::KEY_W-1:0] key_q;
  logic                      out_valid;
  logic                      step;

  assign step         = in_valid && (!out_valid || result.ready);
  assign keypad.ready = !in_valid || step;

  kcl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kcl_core #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (step),
    .key  (key_q),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (keypad.ready) begin
        in_valid <= keypad.valid;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (keypad.valid && keypad.ready) begin
      key_q <= keypad.key;
    end
    if (step) begin
      res_q <= core_res;
    end
  end

  assign result.valid              = out_valid;
  assign result.event_res          = res_q.event_res;
  assign result.relay_on           = res_q.relay_on;
  assign result.digits_entered     = res_q.digits_entered;
  assign result.card_add_mode      = res_q.card_add_mode;
  assign result.card_delete_mode   = res_q.card_delete_mode;
  assign result.finger_enroll_mode = res_q.finger_enroll_mode;
  assign result.locked_out         = res_q.locked_out;

endmodule

`default_nettype wire

/* tb/keypad_code_lock_tb.sv */
// ----------------------------------------------------------------------------
// keypad_code_lock_tb: self-checking testbench of the keypad code lock
// Sends key transactions through the keypad channel and checks every
// transaction on the result channel against an in-bench lock predictor.
// A short table of keys goes first, then random bursts of key sequences
// (unlocks, code changes, triggers, wrong codes, modes, noise) under several
// register settings, with random idling on both sides, one long result stall
// and a final lockout.
// ----------------------------------------------------------------------------
module keypad_code_lock_tb;
  import kcl_pkg::*;

  localparam int CODE_LEN = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [KEY_W-1:0] KEY_ENTER = 4'd15;

  typedef struct {
    logic [KEY_W-1:0] k;
    bit               fixed;
    kcl_event_t       ev;
  } key_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  kcl_key_if key_ch();
  kcl_res_if res_ch();

  keypad_code_lock #(.CODE_DIGITS(CODE_LEN)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .keypad(key_ch),
    .result(res_ch)
  );

  // predicted lock state and register copies
  logic [CFG_W-1:0] cfg_factory = '0;
  logic [CFG_W-1:0] cfg_restore = RESTORE_RST;
  logic [CFG_W-1:0] cfg_clear = CLEAR_RST;
  logic [LIM_W-1:0] cfg_limit = LIMIT_RST;

  logic [3:0] ent [CODE_LEN] = '{default: 4'd0};
  logic [DCNT_W-1:0] ent_cnt = '0;
  logic [CFG_W-1:0] stored = '0;
  logic [CFG_W-1:0] staged = '0;
  logic [1:0] corr = '0;
  logic [LIM_W-1:0] errs = '0;
  logic [1:0] chg_n = '0;
  bit chg_en = 0;
  bit passed = 0;
  bit relay = 0;
  bit locked = 0;
  logic [MODE_W-1:0] modes = '0;

  kcl_res_t pending_results[$];
  kcl_res_t lock_want;
  logic [KEY_W-1:0] key_run[$];

  int mismatches = 0;
  int cycle_count = 0;
  int active_keys = 0;
  bit allow_lock = 0;
  bit steady = 0;
  bit stall_go = 0;
  bit rx_hold = 0;

  key_row_t opening_keys [26] = '{
    '{KEY_ENTER, 1'b1, EV_NONE}, '{KEY_D, 1'b1, EV_REFUSED},
    '{4'd9, 1'b0, EV_NONE}, '{4'd8, 1'b0, EV_NONE}, '{4'd7, 1'b0, EV_NONE},
    '{4'd6, 1'b0, EV_NONE}, '{4'd5, 1'b0, EV_NONE}, '{4'd4, 1'b0, EV_NONE},
    '{4'd9, 1'b1, EV_NONE}, '{KEY_ENTER, 1'b1, EV_WRONG},
    '{4'd0, 1'b0, EV_NONE}, '{4'd0, 1'b0, EV_NONE}, '{4'd0, 1'b0, EV_NONE},
    '{4'd0, 1'b0, EV_NONE}, '{4'd0, 1'b0, EV_NONE}, '{4'd0, 1'b0, EV_NONE},
    '{KEY_ENTER, 1'b1, EV_UNLOCK}, '{KEY_D, 1'b1, EV_NONE},
    '{KEY_A, 1'b1, EV_MODE}, '{4'd3, 1'b1, EV_NONE},
    '{KEY_C, 1'b1, EV_NONE}, '{KEY_A, 1'b1, EV_MODE},
    '{KEY_C, 1'b1, EV_MODE}, '{KEY_B, 1'b1, EV_NONE},
    '{KEY_C, 1'b1, EV_MODE}, '{KEY_CANCEL, 1'b1, EV_CANCEL}
  };

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void clear_entry();
    for (int i = 0; i < CODE_LEN; i++) ent[i] = 4'd0;
    ent_cnt = '0;
  endfunction

  function automatic void go_idle();
    clear_entry();
    corr = '0;
    relay = 0;
  endfunction

  function automatic logic [CFG_W-1:0] entry_code();
    logic [CFG_W-1:0] v;
    v = '0;
    for (int i = 0; i < CODE_LEN; i++) v = {v[CFG_W-5:0], ent[i]};
    return v;
  endfunction

  function automatic logic [CFG_W-1:0] rand_bcd();
    logic [CFG_W-1:0] v;
    v = '0;
    repeat (CODE_LEN) v = {v[CFG_W-5:0], 4'($urandom_range(0, 9))};
    return v;
  endfunction

  // one key through the lock; updates the predicted state
  function automatic kcl_res_t press_key(logic [KEY_W-1:0] k);
    kcl_res_t r;
    kcl_event_t ev;
    logic [MODE_W-1:0] bitm;
    logic [CFG_W-1:0] v;
    ev = EV_NONE;
    if (!locked) begin
      if (k <= KEY_DIGIT_MAX) begin
        if (modes == '0 && ent_cnt < CODE_LEN) begin
          ent[ent_cnt] = k;
          ent_cnt = ent_cnt + 1'b1;
          ev = EV_DIGIT;
        end
      end else if (k == KEY_A || k == KEY_B) begin
        if ((modes & MODE_FP) == '0) begin
          bitm = (k == KEY_A) ? MODE_ADD : MODE_DEL;
          modes = (modes & bitm) ^ bitm;
          ev = EV_MODE;
          if (modes == '0) go_idle();
        end
      end else if (k == KEY_C) begin
        if ((modes & (MODE_ADD | MODE_DEL)) == '0) begin
          modes = modes ^ MODE_FP;
          ev = EV_MODE;
          if ((modes & MODE_FP) == '0) go_idle();
        end
      end else if (modes == '0) begin
        if (k == KEY_D) begin
          if (!passed) begin
            clear_entry();
            ev = EV_REFUSED;
          end else if (chg_en && ent_cnt == CODE_LEN) begin
            chg_n = chg_n + 2'd1;
            if (chg_n == 2'd2) begin
              if (staged == entry_code()) begin
                stored = staged;
                ev = EV_SAVED;
              end else begin
                ev = EV_MISMATCH;
              end
              chg_en = 0;
              chg_n = '0;
              corr = '0;
            end else begin
              staged = entry_code();
              ev = EV_AGAIN;
            end
            clear_entry();
          end
        end else if (k == KEY_CANCEL) begin
          passed = 0;
          chg_en = 0;
          chg_n = '0;
          errs = '0;
          go_idle();
          ev = EV_CANCEL;
        end else if (ent_cnt == CODE_LEN) begin
          v = entry_code();
          if (v == cfg_restore) begin
            stored = cfg_factory;
            ev = EV_RESTORED;
          end else if (v == cfg_clear) begin
            go_idle();
            ev = EV_CLEARFP;
          end else if (v == stored) begin
            corr = corr + 2'd1;
            if (corr == 2'd1) begin
              relay = 1;
              passed = 1;
              ev = EV_UNLOCK;
            end else begin
              chg_en = 1;
              corr = '0;
              ev = EV_CHANGE_ON;
            end
          end else begin
            if (errs != ERR_MAX) errs = errs + 1'b1;
            if (errs >= cfg_limit) begin
              locked = 1;
              relay = 0;
              ev = EV_LOCKOUT;
            end else begin
              ev = EV_WRONG;
            end
          end
          clear_entry();
        end
      end
    end
    r.event_res = ev;
    r.relay_on = relay;
    r.digits_entered = ent_cnt;
    r.card_add_mode = modes[0];
    r.card_delete_mode = modes[1];
    r.finger_enroll_mode = modes[2];
    r.locked_out = locked;
    return r;
  endfunction

  task automatic send_key(logic [KEY_W-1:0] k, bit fixed, kcl_event_t lit);
    kcl_res_t want;
    logic [CFG_W-1:0] v;
    v = entry_code();
    // keep the keypad alive: a wrong code that would lock is swapped for cancel
    if (!allow_lock && k == KEY_ENTER && !locked && modes == '0 && ent_cnt == CODE_LEN &&
        v != cfg_restore && v != cfg_clear && v != stored &&
        ((errs == ERR_MAX) ? errs : errs + 1'b1) >= cfg_limit)
      k = KEY_CANCEL;
    while (!steady && $urandom_range(0, 99) < 20) begin
      key_ch.valid <= 1'b0;
      @(posedge clk);
    end
    key_ch.valid <= 1'b1;
    key_ch.key <= k;
    do @(posedge clk); while (!key_ch.ready);
    want = press_key(k);
    if (fixed) want.event_res = lit;
    if (want.event_res != EV_NONE) active_keys++;
    pending_results.push_back(want);
  endtask

  task automatic drop_modes();
    while (modes != '0)
      send_key((modes & MODE_FP) ? KEY_C : ((modes & MODE_ADD) ? KEY_A : KEY_B), 0, EV_NONE);
  endtask

  function automatic void push_code(logic [CFG_W-1:0] code);
    logic [3:0] nib;
    for (int i = CODE_LEN - 1; i >= 0; i--) begin
      nib = code[4*i +: 4];
      key_run.push_back(nib > KEY_DIGIT_MAX ? 4'($urandom_range(0, 9)) : nib);
    end
  endfunction

  task automatic play_burst();
    int pick;
    logic [CFG_W-1:0] fresh;
    key_run.delete();
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      repeat ($urandom_range(1, 8)) key_run.push_back(4'($urandom_range(0, 15)));
    end else begin
      drop_modes();
      if (ent_cnt != 0 && $urandom_range(0, 1)) key_run.push_back(KEY_CANCEL);
      if (pick < 40) begin
        push_code(stored);
        key_run.push_back(KEY_ENTER);
      end else if (pick < 62) begin
        repeat (2) begin
          push_code(stored);
          key_run.push_back(KEY_ENTER);
        end
        fresh = rand_bcd();
        push_code(fresh);
        key_run.push_back(KEY_D);
        if ($urandom_range(0, 3) == 0) fresh = rand_bcd();
        push_code(fresh);
        key_run.push_back(KEY_D);
      end else if (pick < 72) begin
        push_code($urandom_range(0, 1) ? cfg_restore : cfg_clear);
        key_run.push_back(KEY_ENTER);
      end else if (pick < 82) begin
        push_code(rand_bcd());
        key_run.push_back(KEY_ENTER);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) key_run.push_back(4'($urandom_range(KEY_A, KEY_C)));
        repeat ($urandom_range(0, 2)) key_run.push_back(4'($urandom_range(0, 9)));
      end else if (pick < 95) begin
        key_run.push_back(KEY_CANCEL);
      end else begin
        repeat ($urandom_range(0, CODE_LEN - 1)) key_run.push_back(4'($urandom_range(0, 9)));
        key_run.push_back($urandom_range(0, 1) ? KEY_ENTER : KEY_D);
      end
    end
    foreach (key_run[i]) send_key(key_run[i], 0, EV_NONE);
  endtask

  task automatic run_mix(int target);
    int start;
    start = active_keys;
    while (active_keys - start < target) play_burst();
  endtask

  task automatic settle();
    key_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_FACTORY: cfg_factory = data;
      REG_RESTORE: cfg_restore = data;
      REG_CLEAR: cfg_clear = data;
      REG_LIMIT: cfg_limit = data[LIM_W-1:0];
    endcase
  endtask

  task automatic configure(logic [CFG_W-1:0] factory, logic [CFG_W-1:0] restore,
                           logic [CFG_W-1:0] clear, logic [LIM_W-1:0] limit);
    write_reg(REG_FACTORY, factory);
    write_reg(REG_RESTORE, restore);
    write_reg(REG_CLEAR, clear);
    write_reg(REG_LIMIT, {{(CFG_W-LIM_W){1'b0}}, limit});
    cfg_we <= 1'b0;
  endtask

  task automatic report_mismatch(string msg);
    if (mismatches < 40) $display("cycle %0d: mismatch, %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // result side: random idling, one long hold-off
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= !rx_hold && (steady || $urandom_range(0, 99) >= 20);
    end
  end

  initial begin
    wait (stall_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with nothing pending");
      end else begin
        lock_want = pending_results.pop_front();
        check_field("event_res", 8'(res_ch.event_res), 8'(lock_want.event_res));
        check_field("relay_on", 8'(res_ch.relay_on), 8'(lock_want.relay_on));
        check_field("digits_entered", 8'(res_ch.digits_entered),
                    8'(lock_want.digits_entered));
        check_field("card_add_mode", 8'(res_ch.card_add_mode),
                    8'(lock_want.card_add_mode));
        check_field("card_delete_mode", 8'(res_ch.card_delete_mode),
                    8'(lock_want.card_delete_mode));
        check_field("finger_enroll_mode", 8'(res_ch.finger_enroll_mode),
                    8'(lock_want.finger_enroll_mode));
        check_field("locked_out", 8'(res_ch.locked_out), 8'(lock_want.locked_out));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_FACTORY;
    cfg_data <= '0;
    key_ch.valid <= 1'b0;
    key_ch.key <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_keys[i])
      send_key(opening_keys[i].k, opening_keys[i].fixed, opening_keys[i].ev);
    run_mix(450);

    settle();
    configure(rand_bcd(), rand_bcd(), rand_bcd(), 4'd15);
    stall_go <= 1'b1;
    run_mix(450);

    settle();
    steady <= 1'b1;
    configure(24'h000000, 24'hFFFFFF, 24'h000000, 4'd1);
    run_mix(400);
    steady <= 1'b0;

    settle();
    configure(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 4'($urandom_range(2, 14)));
    run_mix(300);

    settle();
    configure(rand_bcd(), rand_bcd(), rand_bcd(), 4'($urandom_range(2, 14)));
    run_mix(350);

    // wrong codes until the keypad locks, then keys that must be ignored
    settle();
    configure(cfg_factory, cfg_restore, cfg_clear, 4'($urandom_range(1, 4)));
    allow_lock = 1;
    drop_modes();
    send_key(KEY_CANCEL, 0, EV_NONE);
    while (!locked) begin
      repeat (CODE_LEN) send_key(4'($urandom_range(0, 9)), 0, EV_NONE);
      send_key(KEY_ENTER, 0, EV_NONE);
    end
    repeat (40) send_key(4'($urandom_range(0, 15)), 0, EV_NONE);

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
